// ===== rtl/core/esbs_pkg.sv =====
package esbs_pkg;

  localparam int RAT_W   = 12;
  localparam int SUM_W   = 15;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 4;
  localparam int MASK_W  = 8;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CNT_W-1:0]  MAX_SWAP_RST  = 4'd4;
  localparam logic [CFG_AW-1:0] ADDR_MAX_SWAP = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_INIT,
    ST_OUTER,
    ST_INNER,
    ST_DRAIN,
    ST_DONE
  } esbs_state_t;

  typedef struct packed {
    logic wr;
    logic tot;
    logic init;
    logic setup;
    logic o_adv;
    logic i_step;
    logic done;
  } esbs_cmd_t;

  typedef struct packed {
    logic outer_ok;
    logic outer_last;
    logic inner_last;
    logic out_free;
  } esbs_stat_t;

endpackage

// ===== rtl/core/esbs_ctrl.sv =====
module esbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  esbs_pkg::esbs_stat_t stat,
  output logic                 in_ready,
  output esbs_pkg::esbs_cmd_t  cmd
);
  import esbs_pkg::*;

  esbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_last) state_nxt = ST_TOTAL;
      end
      ST_TOTAL: state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_OUTER;
      ST_OUTER: begin
        priority if (stat.outer_ok) state_nxt = ST_INNER;
        else if (stat.outer_last) state_nxt = ST_DRAIN;
        else state_nxt = ST_OUTER;
      end
      ST_INNER: begin
        if (stat.inner_last) state_nxt = stat.outer_last ? ST_DRAIN : ST_OUTER;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.wr   = in_fire;
      end
      ST_TOTAL: cmd.tot = 1'b1;
      ST_INIT:  cmd.init = 1'b1;
      ST_OUTER: begin
        cmd.setup = stat.outer_ok;
        cmd.o_adv = !stat.outer_ok && !stat.outer_last;
      end
      ST_INNER: begin
        cmd.i_step = 1'b1;
        cmd.o_adv  = stat.inner_last && !stat.outer_last;
      end
      ST_DRAIN: ;
      ST_DONE:  cmd.done = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/esbs_dp.sv =====
module esbs_dp #(
  parameter int GROUP_SIZE = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  esbs_pkg::esbs_cmd_t               cmd,
  output esbs_pkg::esbs_stat_t              stat,
  input  logic [esbs_pkg::RAT_W-1:0]        in_rating,
  input  logic                              in_group,
  input  logic [esbs_pkg::SLOT_W-1:0]       in_slot,
  input  logic [esbs_pkg::CNT_W-1:0]        max_swap,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic                              out_heavy_group,
  output logic [esbs_pkg::MASK_W-1:0]       out_heavy_mask,
  output logic [esbs_pkg::MASK_W-1:0]       out_light_mask,
  output logic [esbs_pkg::SUM_W-1:0]        out_gain,
  output logic [esbs_pkg::SUM_W-1:0]        out_new_red_total,
  output logic [esbs_pkg::SUM_W-1:0]        out_new_blue_total
);
  import esbs_pkg::*;

  localparam int G     = GROUP_SIZE;
  localparam int IDX_W = $clog2(G);

  logic [RAT_W-1:0]  red_r  [G];
  logic [RAT_W-1:0]  blue_r [G];
  logic [RAT_W-1:0]  h_rat  [G];
  logic [RAT_W-1:0]  l_rat  [G];

  logic [SUM_W-1:0]  red_tot_r, blue_tot_r, target_r, best_gain_r;
  logic              heavy_r;
  logic [G-1:0]      best_hmask_r, best_lmask_r;
  logic [G-1:0]      outer_r, inner_r, hmask_r;
  logic [SUM_W-1:0]  hsum_r;
  logic              p_valid_r;
  logic [SUM_W-1:0]  p_hsum_r, p_lsum_r;
  logic [G-1:0]      p_hmask_r, p_lmask_r;
  logic              out_valid_r;
  logic              res_found_r, res_heavy_r;
  logic [MASK_W-1:0] res_hmask_r, res_lmask_r;
  logic [SUM_W-1:0]  res_gain_r, res_red_r, res_blue_r;

  logic [SUM_W-1:0]  red_sum_c, blue_sum_c, hsum_c, lsum_c, diff_c;
  logic [CNT_W-1:0]  hc_c, tz_c;
  logic [G-1:0]      orev_c, irev_c, inner_init_c, inner_next_c;
  logic [G:0]        gv_c, gc_c, gr_c, gx_c;
  logic              slot_ok_c;

  always_comb begin
    for (int i = 0; i < G; i++) begin
      h_rat[i] = heavy_r ? blue_r[i] : red_r[i];
      l_rat[i] = heavy_r ? red_r[i] : blue_r[i];
    end
  end

  always_comb begin
    red_sum_c  = '0;
    blue_sum_c = '0;
    hsum_c     = '0;
    lsum_c     = '0;
    hc_c       = '0;
    tz_c       = '0;
    for (int b = 0; b < G; b++) begin
      red_sum_c  = red_sum_c + SUM_W'(red_r[b]);
      blue_sum_c = blue_sum_c + SUM_W'(blue_r[b]);
      orev_c[G-1-b] = outer_r[b];
      irev_c[G-1-b] = inner_r[b];
      if (outer_r[b]) hsum_c = hsum_c + SUM_W'(h_rat[G-1-b]);
      if (inner_r[b]) lsum_c = lsum_c + SUM_W'(l_rat[G-1-b]);
      hc_c = hc_c + CNT_W'(outer_r[b]);
    end
    for (int b = G - 1; b >= 0; b--) begin
      if (inner_r[b]) tz_c = CNT_W'(b);
    end
    for (int b = 0; b < G; b++) begin
      inner_init_c[b] = CNT_W'(b) < hc_c;
    end
  end

  // next subset number with the same member count, in ascending order
  always_comb begin
    gv_c         = {1'b0, inner_r};
    gc_c         = gv_c & (~gv_c + 1'b1);
    gr_c         = gv_c + gc_c;
    gx_c         = ((gr_c ^ gv_c) >> 2) >> tz_c;
    inner_next_c = gr_c[G-1:0] | gx_c[G-1:0];
  end

  assign slot_ok_c = {1'b0, in_slot} < CNT_W'(G);
  assign diff_c    = p_hsum_r - p_lsum_r;

  assign stat.outer_ok   = hc_c <= max_swap;
  assign stat.outer_last = &outer_r;
  assign stat.inner_last = gr_c[G];
  assign stat.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok_c) begin
      if (in_group) blue_r[in_slot[IDX_W-1:0]] <= in_rating;
      else          red_r[in_slot[IDX_W-1:0]]  <= in_rating;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tot) begin
      red_tot_r  <= red_sum_c;
      blue_tot_r <= blue_sum_c;
    end
    if (cmd.init) begin
      heavy_r      <= !(red_tot_r > blue_tot_r);
      target_r     <= (red_tot_r > blue_tot_r) ? (red_tot_r - blue_tot_r) >> 1
                                               : (blue_tot_r - red_tot_r) >> 1;
      outer_r      <= G'(1);
    end
    if (cmd.setup) begin
      hsum_r  <= hsum_c;
      hmask_r <= orev_c;
      inner_r <= inner_init_c;
    end
    if (cmd.o_adv) outer_r <= outer_r + 1'b1;
    if (cmd.i_step) begin
      inner_r   <= inner_next_c;
      p_hsum_r  <= hsum_r;
      p_hmask_r <= hmask_r;
      p_lsum_r  <= lsum_c;
      p_lmask_r <= irev_c;
    end
    if (cmd.init) begin
      best_gain_r  <= '0;
      best_hmask_r <= '0;
      best_lmask_r <= '0;
    end else if (p_valid_r && (p_hsum_r > p_lsum_r) && (diff_c <= target_r) &&
                 (diff_c > best_gain_r)) begin
      best_gain_r  <= diff_c;
      best_hmask_r <= p_hmask_r;
      best_lmask_r <= p_lmask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.i_step;
      if (cmd.done) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      res_found_r <= best_gain_r != '0;
      res_heavy_r <= heavy_r;
      res_hmask_r <= MASK_W'(best_hmask_r);
      res_lmask_r <= MASK_W'(best_lmask_r);
      res_gain_r  <= best_gain_r;
      res_red_r   <= heavy_r ? red_tot_r + best_gain_r : red_tot_r - best_gain_r;
      res_blue_r  <= heavy_r ? blue_tot_r - best_gain_r : blue_tot_r + best_gain_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = res_found_r;
  assign out_heavy_group    = res_heavy_r;
  assign out_heavy_mask     = res_hmask_r;
  assign out_light_mask     = res_lmask_r;
  assign out_gain           = res_gain_r;
  assign out_new_red_total  = res_red_r;
  assign out_new_blue_total = res_blue_r;

endmodule

// ===== rtl/core/equal_size_swap_balance_search.sv =====
// Equal-size swap balance search.
// Input stream: one rating per transaction. in_tdata holds the rating and its
// slot, in_tuser the group (0 red, 1 blue), in_tlast marks the final load item.
// in_tready is high while the block is loading. The transaction with in_tlast set
// stores its rating and starts a search over all pairs of equal-size subsets,
// one from each group, of up to max_swap_size members. The search visits 8884
// equal-size subset pairs for eight slots and swap size four; the inner subset
// adder handles one pair per cycle while the search is in its inner loop.
// One result transaction follows each search on out_*; in_tready stays low until
// the result is placed in the output register, and a waiting result does not
// block the next group of load transactions.
// A stalled receiver holds the result in the output register; a finished search
// waits for it to drain before loading the next one.
// max_swap_size is written over the APB-style port at byte address 0 (reset 4).
// rst_n is synchronous: it returns to loading, drops any pending result and
// restores max_swap_size; stored ratings are undefined until loaded.
module equal_size_swap_balance_search #(
  parameter int GROUP_SIZE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // rating[11:0], slot[14:12], zero[15]
  input  logic                          in_tuser,   // group[0]
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,  // heavy_mask[7:0], light_mask[15:8],
                                                    // gain[30:16], new_red_total[45:31],
                                                    // new_blue_total[60:46], zero[63:61]
  output logic [1:0]                    out_tuser,  // found[0], heavy_group[1]
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [esbs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [esbs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [esbs_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import esbs_pkg::*;

  logic [CNT_W-1:0]  max_swap_r;
  logic              cfg_hit;
  logic              in_fire;
  esbs_cmd_t         cmd;
  esbs_stat_t        stat;
  logic              found, heavy_group;
  logic [MASK_W-1:0] heavy_mask, light_mask;
  logic [SUM_W-1:0]  gain, new_red_total, new_blue_total;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr == ADDR_MAX_SWAP;
  assign cfg_prdata = cfg_hit ? CFG_DW'(max_swap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_swap_r <= MAX_SWAP_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      max_swap_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign in_fire = in_tvalid && in_tready;

  esbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_last  (in_tlast),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  esbs_dp #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_rating          (in_tdata[RAT_W-1:0]),
    .in_group           (in_tuser),
    .in_slot            (in_tdata[RAT_W+SLOT_W-1:RAT_W]),
    .max_swap           (max_swap_r),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_found          (found),
    .out_heavy_group    (heavy_group),
    .out_heavy_mask     (heavy_mask),
    .out_light_mask     (light_mask),
    .out_gain           (gain),
    .out_new_red_total  (new_red_total),
    .out_new_blue_total (new_blue_total)
  );

  assign out_tdata = {3'b000, new_blue_total, new_red_total, gain, light_mask, heavy_mask};
  assign out_tuser = {heavy_group, found};

endmodule
